// ----- rtl/shtd_pkg.sv -----
// ----------------------------------------------------------------------------
// shtd_pkg: shared definitions for the shared-hit track dedup block
// types, defaults and the controller/datapath command and status structs
// ----------------------------------------------------------------------------
package shtd_pkg;

    localparam int unsigned MaxTracksDef  = 64;
    localparam int unsigned MaxHitsDef    = 4;
    localparam int unsigned HitIdBitsDef  = 16;
    localparam int unsigned IdFields      = 4;
    localparam int unsigned InIdW         = 16;
    localparam int unsigned CountW        = 3;
    localparam int unsigned ScoreW        = 32;
    localparam int unsigned IndexW        = 6;
    localparam int unsigned MaxResults    = 64;
    localparam int unsigned InDataW       = 104; // 4*16 + 3 + 32 = 99, padded
    localparam int unsigned OutDataW      = 8;

    localparam logic [2:0] AllShared = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;      // write incoming track at fill count
        logic rd_req;    // issue read of pair (i, j)
        logic judge;     // pair data valid: evaluate rule
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic drop_i;  // valid during judge
        logic drop_j;
    } t_sts;

endpackage

// ----- rtl/shared_hit_track_dedup.sv -----
// ----------------------------------------------------------------------------
// shared_hit_track_dedup: removal of tracks that share hits, one event a time
// loads tracks, sweeps pairs in load order, then streams survivor indices
// ----------------------------------------------------------------------------
//
// channel | dir | tdata                          | tlast
// s_axis  | in  | ids a..d, hit_count, fit_score | last_track
// m_axis  | out | track_index, kept_valid, ovf   | last_result
//
// loading takes one track a cycle; in the pair sweep every compared pair is a
// registered store read, then the rule
// output gives one word a cycle while the sink is ready and no removed track
// is skipped; the input reopens the cycle after the last word is taken
// s_axis_tready is low from the last track until the event has drained
// reset (i_rst_n, synchronous) clears the fill count, marks and flags
//
module shared_hit_track_dedup #(
    parameter int unsigned MAX_TRACKS  = shtd_pkg::MaxTracksDef,
    parameter int unsigned MAX_HITS    = shtd_pkg::MaxHitsDef,
    parameter int unsigned HIT_ID_BITS = shtd_pkg::HitIdBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // hit_id_a, hit_id_b, hit_id_c, hit_id_d, hit_count, fit_score, zero pad
    input  logic [shtd_pkg::InDataW-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // track_index, kept_valid, overflow
    output logic [shtd_pkg::OutDataW-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);
    import shtd_pkg::*;

    localparam int unsigned AW = $clog2(MAX_TRACKS);

    t_cmd            cmd;
    t_sts            sts;
    logic [AW-1:0]   wr_addr, rd_i, rd_j;

    // sequencer with fill count, removed marks and output register
    shtd_ctrl #(.MAX_TRACKS(MAX_TRACKS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_wr_addr   (wr_addr),
        .o_rd_i      (rd_i),
        .o_rd_j      (rd_j),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // track store and pair rule
    shtd_datapath #(
        .MAX_TRACKS  (MAX_TRACKS),
        .MAX_HITS    (MAX_HITS),
        .HIT_ID_BITS (HIT_ID_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_data    (s_axis_tdata),
        .i_wr_addr (wr_addr),
        .i_rd_i    (rd_i),
        .i_rd_j    (rd_j),
        .i_cmd     (cmd),
        .o_sts     (sts)
    );

    // a pair never removes both tracks
    a_one_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sts.drop_i && sts.drop_j))
        else $error("both tracks of a pair dropped");

    // no loading while results are on the way out
    a_no_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open during output");

    // a word marked kept_valid 0 must end the event
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[6]) |-> m_axis_tlast)
        else $error("empty result not last");

endmodule

// ----- rtl/shtd_datapath.sv -----
// ----------------------------------------------------------------------------
// shtd_datapath: track store, pair compare and removal rule
// three memories with registered read ports, one pair judged per read
// ----------------------------------------------------------------------------
module shtd_datapath #(
    parameter int unsigned MAX_TRACKS  = shtd_pkg::MaxTracksDef,
    parameter int unsigned MAX_HITS    = shtd_pkg::MaxHitsDef,
    parameter int unsigned HIT_ID_BITS = shtd_pkg::HitIdBitsDef,
    parameter int unsigned AW          = $clog2(MAX_TRACKS)
) (
    input  logic                            i_clk,
    input  logic [shtd_pkg::InDataW-1:0]    i_data,
    input  logic [AW-1:0]                   i_wr_addr,
    input  logic [AW-1:0]                   i_rd_i,
    input  logic [AW-1:0]                   i_rd_j,
    input  shtd_pkg::t_cmd                  i_cmd,
    output shtd_pkg::t_sts                  o_sts
);
    import shtd_pkg::*;

    localparam int unsigned IdW = (HIT_ID_BITS < InIdW) ? HIT_ID_BITS : InIdW;
    localparam int unsigned Cap = (MAX_HITS < IdFields) ? MAX_HITS : IdFields;
    localparam logic [CountW-1:0] CapC = CountW'(Cap);
    localparam logic [CountW-1:0] Three = 3'd3;

    logic [IdFields*IdW-1:0] r_hit_mem [MAX_TRACKS];
    logic [CountW-1:0]       r_cnt_mem [MAX_TRACKS];
    logic [ScoreW-1:0]       r_scr_mem [MAX_TRACKS];

    logic [IdFields*IdW-1:0] r_hit_i, r_hit_j;
    logic [CountW-1:0]       r_cnt_i, r_cnt_j;
    logic [ScoreW-1:0]       r_scr_i, r_scr_j;

    logic [IdFields*IdW-1:0] n_hits;
    logic [CountW-1:0]       in_cnt, n_cnt;

    always_comb begin
        for (int k = 0; k < IdFields; k++) begin
            n_hits[k*IdW +: IdW] = i_data[k*InIdW +: IdW];
        end
        in_cnt = i_data[IdFields*InIdW +: CountW];
        n_cnt  = (in_cnt > CapC) ? CapC : in_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit_mem[i_wr_addr] <= n_hits;
            r_cnt_mem[i_wr_addr] <= n_cnt;
            r_scr_mem[i_wr_addr] <= i_data[IdFields*InIdW+CountW +: ScoreW];
        end
        if (i_cmd.rd_req) begin
            r_hit_i <= r_hit_mem[i_rd_i];
            r_cnt_i <= r_cnt_mem[i_rd_i];
            r_scr_i <= r_scr_mem[i_rd_i];
            r_hit_j <= r_hit_mem[i_rd_j];
            r_cnt_j <= r_cnt_mem[i_rd_j];
            r_scr_j <= r_scr_mem[i_rd_j];
        end
    end

    // shared count: each valid hit of i found among valid hits of j
    logic [CountW-1:0] shared;
    logic              found, hit_rule;

    always_comb begin
        shared = '0;
        for (int x = 0; x < IdFields; x++) begin
            found = 1'b0;
            for (int y = 0; y < IdFields; y++) begin
                if (CountW'(y) < r_cnt_j &&
                    r_hit_i[x*IdW +: IdW] == r_hit_j[y*IdW +: IdW]) begin
                    found = 1'b1;
                end
            end
            if (CountW'(x) < r_cnt_i && found) begin
                shared = shared + 1'b1;
            end
        end
        hit_rule = (shared >= 3'd2) ||
                   (shared == 3'd1 && r_cnt_i == Three && r_cnt_j == Three);
        o_sts.drop_i = 1'b0;
        o_sts.drop_j = 1'b0;
        if (i_cmd.judge) begin
            priority if (shared == AllShared) begin
                o_sts.drop_i = 1'b1;
            end else if (hit_rule) begin
                if (r_cnt_i > r_cnt_j) begin
                    o_sts.drop_j = 1'b1;
                end else if (r_cnt_j > r_cnt_i) begin
                    o_sts.drop_i = 1'b1;
                end else if (r_scr_i > r_scr_j) begin
                    o_sts.drop_j = 1'b1;
                end else begin
                    o_sts.drop_i = 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/shtd_ctrl.sv -----
// ----------------------------------------------------------------------------
// shtd_ctrl: load, pair sweep and survivor output sequencer
// owns fill count, removed marks, overflow flag and the output register
// ----------------------------------------------------------------------------
module shtd_ctrl #(
    parameter int unsigned MAX_TRACKS = shtd_pkg::MaxTracksDef,
    parameter int unsigned AW         = $clog2(MAX_TRACKS),
    parameter int unsigned CW         = $clog2(MAX_TRACKS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_last,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [shtd_pkg::OutDataW-1:0] o_out_data,
    output logic                         o_out_last,
    output logic [AW-1:0]                o_wr_addr,
    output logic [AW-1:0]                o_rd_i,
    output logic [AW-1:0]                o_rd_j,
    output shtd_pkg::t_cmd               o_cmd,
    input  shtd_pkg::t_sts               i_sts
);
    import shtd_pkg::*;

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_SCANI = 6'b000010,
        S_SCANJ = 6'b000100,
        S_JUDGE = 6'b001000,
        S_EMIT  = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_fill, n_fill;
    logic                r_ovf, n_ovf;
    logic [MAX_TRACKS-1:0] r_rm, n_rm;
    logic [CW-1:0]       r_i, n_i, r_j, n_j;
    logic [6:0]          r_nres, n_nres;
    logic                r_any, n_any;
    logic                r_ov, n_ov;
    logic [OutDataW-1:0] r_od, n_od;
    logic                r_ol, n_ol;

    logic                acc, full;
    logic                more_surv;
    logic                is_last;

    assign o_in_ready = (r_state == S_LOAD);
    assign acc        = i_in_valid && o_in_ready;
    assign full       = (r_fill == CW'(MAX_TRACKS));
    assign o_wr_addr  = r_fill[AW-1:0];
    assign o_rd_i     = r_i[AW-1:0];
    assign o_rd_j     = r_j[AW-1:0];
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
    assign o_out_last  = r_ol;

    // any unremoved track at index above r_i (output phase lookahead)
    always_comb begin
        more_surv = 1'b0;
        for (int k = 0; k < MAX_TRACKS; k++) begin
            if (CW'(k) > r_i && CW'(k) < r_fill && !r_rm[k]) begin
                more_surv = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_ovf   = r_ovf;
        n_rm    = r_rm;
        n_i     = r_i;
        n_j     = r_j;
        n_nres  = r_nres;
        n_any   = r_any;
        n_ov    = r_ov;
        n_od    = r_od;
        n_ol    = r_ol;
        o_cmd   = '0;
        is_last = 1'b0;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_LOAD: begin
                if (acc) begin
                    if (!full) begin
                        o_cmd.load = 1'b1;
                        n_rm[r_fill[AW-1:0]] = 1'b0;
                        n_fill = r_fill + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_last) begin
                        n_i = '0;
                        n_state = S_SCANI;
                    end
                end
            end
            S_SCANI: begin
                if (r_i >= r_fill) begin
                    n_i = '0;
                    n_nres = '0;
                    n_any = 1'b0;
                    n_state = S_EMIT;
                end else if (r_rm[r_i[AW-1:0]]) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_i + 1'b1;
                    n_state = S_SCANJ;
                end
            end
            S_SCANJ: begin
                if (r_j >= r_fill) begin
                    n_i = r_i + 1'b1;
                    n_state = S_SCANI;
                end else if (r_rm[r_j[AW-1:0]]) begin
                    n_j = r_j + 1'b1;
                end else begin
                    o_cmd.rd_req = 1'b1;
                    n_state = S_JUDGE;
                end
            end
            S_JUDGE: begin
                o_cmd.judge = 1'b1;
                if (i_sts.drop_i) begin
                    n_rm[r_i[AW-1:0]] = 1'b1;
                    n_i = r_i + 1'b1;
                    n_state = S_SCANI;
                end else begin
                    if (i_sts.drop_j) begin
                        n_rm[r_j[AW-1:0]] = 1'b1;
                    end
                    n_j = r_j + 1'b1;
                    n_state = S_SCANJ;
                end
            end
            S_EMIT: begin
                // output register free or emptying this cycle
                if (!r_ov || i_out_ready) begin
                    if (r_i >= r_fill) begin
                        if (!r_any) begin
                            n_ov = 1'b1;
                            n_od = {r_ovf, 1'b0, IndexW'(0)};
                            n_ol = 1'b1;
                        end
                        n_state = S_WAIT;
                    end else if (r_rm[r_i[AW-1:0]]) begin
                        n_i = r_i + 1'b1;
                    end else begin
                        is_last = !more_surv || (r_nres == 7'(MaxResults - 1));
                        n_ov = 1'b1;
                        n_od = {r_ovf, 1'b1, IndexW'(r_i)};
                        n_ol = is_last;
                        n_any = 1'b1;
                        n_nres = r_nres + 1'b1;
                        n_i = is_last ? r_fill : r_i + 1'b1;
                        n_state = is_last ? S_WAIT : S_EMIT;
                    end
                end
            end
            S_WAIT: begin
                if (!r_ov || i_out_ready) begin
                    n_fill = '0;
                    n_ovf = 1'b0;
                    n_rm = '0;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_rm    <= '0;
            r_ov    <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_nres  <= '0;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
            r_rm    <= n_rm;
            r_ov    <= n_ov;
            r_i     <= n_i;
            r_j     <= n_j;
            r_nres  <= n_nres;
            r_any   <= n_any;
        end
        r_od <= n_od;
        r_ol <= n_ol;
    end

endmodule

// ----- tb/sv/tb_shared_hit_track_dedup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_hit_track_dedup: self-checking bench for the shared-hit dedup block
// drives events of tracks on s_axis and checks every survivor word on m_axis
// against a behavioural sweep of the pair rules or a typed-in word, with random gaps both sides
// ----------------------------------------------------------------------------
module tb_shared_hit_track_dedup;
    import shtd_pkg::*;

    localparam int unsigned Capacity = MaxTracksDef;
    localparam int unsigned TargetItems = 260;

    // one track as offered on s_axis
    typedef struct {
        logic [InIdW-1:0]  ids [IdFields];
        logic [CountW-1:0] hit_count;
        logic [ScoreW-1:0] fit_score;
        logic              last_track;
    } track_t;

    // one survivor word
    typedef struct packed {
        logic [IndexW-1:0] track_index;
        logic              kept_valid;
        logic              overflow;
        logic              last_result;
    } survivor_t;

    // directed row: expected word typed in only where obvious
    typedef struct {
        track_t    trk;
        logic      typed;
        survivor_t want;
    } row_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;  // ids a..d, hit_count, fit_score, zero pad
    logic                s_axis_tlast;  // last_track
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;  // track_index, kept_valid, overflow
    logic                m_axis_tlast;  // last_result

    shared_hit_track_dedup u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor copy of the event store
    logic [InIdW-1:0]  ev_ids   [Capacity][IdFields];
    logic [2:0]        ev_count [Capacity];
    logic [ScoreW-1:0] ev_score [Capacity];
    logic              ev_gone  [Capacity];
    int unsigned       ev_loaded;
    logic              ev_ovf;

    survivor_t   survivors_q [$];
    int unsigned fail_cnt;
    int unsigned words_seen;
    int unsigned items_sent;
    int unsigned events_sent;
    int unsigned overflow_events;
    logic        steady;   // no idling on either side while high

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous overall limit
    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int unsigned common_hits(int unsigned a, int unsigned b);
        int unsigned n;
        n = 0;
        for (int x = 0; x < ev_count[a]; x++) begin
            for (int y = 0; y < ev_count[b]; y++) begin
                if (ev_ids[a][x] == ev_ids[b][y]) begin
                    n++;
                    break;
                end
            end
        end
        return n;
    endfunction

    // pair sweep in load order, then queue the survivor words
    function automatic void sweep_event(output survivor_t words [$]);
        int unsigned n;
        int unsigned ci;
        int unsigned cj;
        survivor_t w;
        words = {};
        for (int unsigned i = 0; i < ev_loaded; i++) begin
            if (ev_gone[i]) continue;
            for (int unsigned j = i + 1; j < ev_loaded; j++) begin
                if (ev_gone[j]) continue;
                n  = common_hits(i, j);
                ci = ev_count[i];
                cj = ev_count[j];
                if (n == AllShared) begin
                    ev_gone[i] = 1'b1;
                    break;
                end
                if (n >= 2 || (n == 1 && ci == 3 && cj == 3)) begin
                    if (ci > cj) begin
                        ev_gone[j] = 1'b1;
                    end else if (cj > ci) begin
                        ev_gone[i] = 1'b1;
                        break;
                    end else if (ev_score[i] > ev_score[j]) begin
                        ev_gone[j] = 1'b1;
                    end else begin
                        ev_gone[i] = 1'b1;
                        break;
                    end
                end
            end
        end
        for (int unsigned i = 0; i < ev_loaded && words.size() < MaxResults; i++) begin
            if (ev_gone[i]) continue;
            w = '{track_index: i[IndexW-1:0], kept_valid: 1'b1, overflow: ev_ovf,
                  last_result: 1'b0};
            words = {words, w};
        end
        if (words.size() == 0) begin
            w = '{track_index: '0, kept_valid: 1'b0, overflow: ev_ovf, last_result: 1'b1};
            words = {words, w};
        end else begin
            words[$].last_result = 1'b1;
        end
        for (int unsigned i = 0; i < Capacity; i++) ev_gone[i] = 1'b0;
        ev_loaded = 0;
        ev_ovf    = 1'b0;
    endfunction

    // accepted track: store it, and on the event's last track predict the words
    task automatic take_track(input track_t t, input logic typed, input survivor_t want);
        survivor_t words [$];
        if (ev_loaded < Capacity) begin
            for (int k = 0; k < IdFields; k++) ev_ids[ev_loaded][k] = t.ids[k];
            ev_count[ev_loaded] = (t.hit_count > MaxHitsDef) ? 3'(MaxHitsDef) : t.hit_count;
            ev_score[ev_loaded] = t.fit_score;
            ev_gone[ev_loaded]  = 1'b0;
            ev_loaded++;
        end else begin
            ev_ovf = 1'b1;
        end
        if (t.last_track) begin
            if (ev_ovf) overflow_events++;
            events_sent++;
            sweep_event(words);
            if (typed) survivors_q = {survivors_q, want};
            else survivors_q = {survivors_q, words};
        end
    endtask

    // present one track from the falling edge and hold it until taken
    task automatic send_track(input track_t t, input logic typed, input survivor_t want);
        if (!steady && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, t.fit_score, t.hit_count,
                          t.ids[3], t.ids[2], t.ids[1], t.ids[0]};
        s_axis_tlast  <= t.last_track;
        do @(posedge i_clk); while (!s_axis_tready);
        take_track(t, typed, want);
        items_sent++;
        @(negedge i_clk);
    endtask

    // random id, mostly from a small pool so that tracks share hits
    function automatic logic [InIdW-1:0] pick_id(int unsigned pool);
        if ($urandom_range(9) == 0) return InIdW'($urandom);
        return InIdW'($urandom_range(pool));
    endfunction

    function automatic track_t rand_track(int unsigned pool, logic last);
        track_t t;
        for (int k = 0; k < IdFields; k++) t.ids[k] = pick_id(pool);
        t.hit_count  = ($urandom_range(9) == 0) ? CountW'($urandom_range(5, 7))
                                                : CountW'($urandom_range(4));
        t.fit_score  = ($urandom_range(3) == 0) ? ScoreW'($urandom_range(3))
                                                : ScoreW'($urandom);
        t.last_track = last;
        return t;
    endfunction

    // sink side: random back-pressure except in the steady stretch
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 28);
    end

    // output checker against the oldest expected word
    always @(posedge i_clk) begin
        survivor_t got;
        survivor_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{track_index: m_axis_tdata[5:0], kept_valid: m_axis_tdata[6],
                    overflow: m_axis_tdata[7], last_result: m_axis_tlast};
            words_seen++;
            if (survivors_q.size() == 0) begin
                $error("unexpected word: track_index %0d", got.track_index);
                fail_cnt++;
            end else begin
                want = survivors_q.pop_front();
                if (got.track_index !== want.track_index) begin
                    $error("track_index: expected %0d, got %0d",
                           want.track_index, got.track_index);
                    fail_cnt++;
                end
                if (got.kept_valid !== want.kept_valid) begin
                    $error("kept_valid: expected %0b, got %0b", want.kept_valid, got.kept_valid);
                    fail_cnt++;
                end
                if (got.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                    fail_cnt++;
                end
                if (got.last_result !== want.last_result) begin
                    $error("last_result: expected %0b, got %0b",
                           want.last_result, got.last_result);
                    fail_cnt++;
                end
            end
        end
    end

    // directed rows: extremes, saturation, the pair rules and their tie
    row_t rows [] = '{
        // lone empty track survives
        '{'{'{16'h0, 16'h0, 16'h0, 16'h0}, 3'd0, 32'h0, 1'b1}, 1'b1,
          '{6'd0, 1'b1, 1'b0, 1'b1}},
        // all four shared: first of the pair goes
        '{'{'{16'd1, 16'd2, 16'd3, 16'd4}, 3'd4, 32'd5, 1'b0}, 1'b0, '0},
        '{'{'{16'd4, 16'd3, 16'd2, 16'd1}, 3'd4, 32'hFFFF_FFFF, 1'b1}, 1'b1,
          '{6'd1, 1'b1, 1'b0, 1'b1}},
        // saturated count, two shared, equal counts: first has the larger score, second goes
        '{'{'{16'hFFFF, 16'hFFFE, 16'hFFFD, 16'h0}, 3'd7, 32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{'{16'hFFFF, 16'hFFFE, 16'd9, 16'd9}, 3'd4, 32'h0, 1'b1}, 1'b1,
          '{6'd0, 1'b1, 1'b0, 1'b1}},
        // one shared between three-hit tracks, equal scores
        '{'{'{16'd10, 16'd11, 16'd12, 16'hAAAA}, 3'd3, 32'd7, 1'b0}, 1'b0, '0},
        '{'{'{16'd12, 16'd20, 16'd21, 16'h5555}, 3'd3, 32'd7, 1'b1}, 1'b0, '0},
        // repeated ids, fewer hits loses, zero-hit track
        '{'{'{16'd5, 16'd5, 16'd6, 16'd0}, 3'd3, 32'd100, 1'b0}, 1'b0, '0},
        '{'{'{16'd5, 16'd7, 16'd8, 16'd0}, 3'd3, 32'd1, 1'b0}, 1'b0, '0},
        '{'{'{16'd5, 16'd6, 16'd9, 16'd9}, 3'd4, 32'd200, 1'b0}, 1'b0, '0},
        '{'{'{16'd5, 16'd6, 16'd9, 16'd9}, 3'd0, 32'd0, 1'b0}, 1'b0, '0},
        '{'{'{16'd9, 16'd6, 16'd1, 16'd2}, 3'd2, 32'd3, 1'b0}, 1'b0, '0},
        '{'{'{16'd9, 16'd6, 16'd5, 16'd8}, 3'd5, 32'd3, 1'b1}, 1'b0, '0},
        // one shared only, four-hit tracks: both stay
        '{'{'{16'd30, 16'd31, 16'd32, 16'd33}, 3'd4, 32'd1, 1'b0}, 1'b0, '0},
        '{'{'{16'd33, 16'd40, 16'd41, 16'd42}, 3'd6, 32'd2, 1'b1}, 1'b0, '0}
    };

    initial begin
        track_t t;
        int unsigned ev_len;
        int unsigned pool;
        int unsigned guard;
        logic big_done;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        steady        = 1'b0;
        fail_cnt = 0; words_seen = 0; items_sent = 0; events_sent = 0;
        overflow_events = 0; ev_loaded = 0; ev_ovf = 1'b0;
        big_done = 1'b0;
        for (int unsigned i = 0; i < Capacity; i++) ev_gone[i] = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[r]) send_track(rows[r].trk, rows[r].typed, rows[r].want);

        // random events, mostly small; one full store and one overflowing event
        while (items_sent < TargetItems) begin
            steady <= (events_sent >= 12 && events_sent < 20);
            if (!big_done && events_sent == 14) begin
                // full store of distinct tracks, then an event three tracks beyond capacity
                for (int unsigned k = 0; k < Capacity; k++) begin
                    t = rand_track(0, 1'b0);
                    for (int q = 0; q < IdFields; q++) t.ids[q] = InIdW'(k * 8 + q);
                    t.last_track = (k == Capacity - 1);
                    send_track(t, 1'b0, '0);
                end
                for (int unsigned k = 0; k < Capacity + 3; k++)
                    send_track(rand_track(30, k == Capacity + 2), 1'b0, '0);
                big_done = 1'b1;
            end else begin
                ev_len = ($urandom_range(7) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(1, 12);
                pool   = $urandom_range(3, 40);
                for (int unsigned k = 0; k < ev_len; k++)
                    send_track(rand_track(pool, k == ev_len - 1), 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        steady        <= 1'b0;

        guard = 0;
        while (survivors_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (50) @(posedge i_clk);
        if (survivors_q.size() != 0) begin
            $error("%0d expected words never arrived", survivors_q.size());
            fail_cnt++;
        end

        $display("ran %0d tracks in %0d events (%0d over capacity), checked %0d words",
                 items_sent, events_sent, overflow_events, words_seen);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
